>>> hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is asserted
`define IPBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipba check failed");

// next-cycle implication, skipped while reset is asserted
`define IPBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipba check failed");

`endif

>>> hdl/ipba_pkg.sv
// types, codes and constants of the prefix bitmap allocator
`default_nettype none
package ipba_pkg;

    localparam int HALF_W      = 64;
    localparam int LEN_W       = 8;
    localparam int CNT_W       = 13;
    localparam int IDX_OUT_W   = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int DEF_MAX_PREFIXES = 4096;

    localparam logic [LEN_W-1:0] FULL_LEN    = 8'd128;
    localparam logic [LEN_W-1:0] RESET_LEN   = 8'd64;
    localparam logic [CNT_W-1:0] RESET_COUNT = 13'd4096;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR  = 2'd2;
    localparam logic [1:0] ST_NO_CHANGE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_START_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_ID = 3'd4;

    typedef struct packed {
        logic [1:0]        operation;
        logic [HALF_W-1:0] addr_high;
        logic [HALF_W-1:0] addr_low;
    } t_in;

    typedef struct packed {
        logic [1:0]           status;
        logic [IDX_OUT_W-1:0] bit_index;
        logic [HALF_W-1:0]    result_high;
        logic [HALF_W-1:0]    result_low;
        logic [LEN_W-1:0]     result_prefix_len;
        logic [HALF_W-1:0]    local_interface_id;
        logic [HALF_W-1:0]    peer_interface_id;
        logic [CNT_W-1:0]     used_count;
    } t_out;

    typedef struct packed {
        logic       clr;
        logic       take_in;
        logic       scan_start;
        logic       scan_run;
        logic       commit_alloc;
        logic       stage_alloc;
        logic       addr_sub;
        logic       addr_align;
        logic       addr_read;
        logic       addr_update;
        logic       stage_fail;
        logic [1:0] fail_code;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic count_zero;
        logic scan_hit;
        logic scan_miss;
        logic addr_ok;
    } t_sts;

endpackage
`default_nettype wire

>>> hdl/ipv6_prefix_bitmap_allocator_unit.sv
// top level of the next-fit IPv6 prefix bitmap allocator
//
//  channel | direction | handshake                    | payload
//  in      | input     | i_in_valid / o_in_ready      | i_in  (t_in)
//  out     | output    | o_out_valid / i_out_ready    | o_out (t_out)
//  cfg     | input     | i_cfg_we, no wait            | i_cfg_idx, i_cfg_data
//
// allocate: next-fit scan of the bitmap, one bitmap word read per cycle
// release and reserve: subtract, shift, memory read and bitmap update in turn; a bad address skips the update
// count zero or an unknown operation: the failure is staged straight from idle, with no bitmap access
// after reset a clearing pass writes all DEPTH bitmap words, one per cycle
// one beat is in work at a time; a new beat is taken while the last result waits
// a stalled output holds the next result in staging until the output register frees
`default_nettype none
module ipv6_prefix_bitmap_allocator_unit
    import ipba_pkg::*;
#(
    parameter int MAX_PREFIXES = DEF_MAX_PREFIXES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in                  i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out                      o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [HALF_W-1:0]    i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    ipba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in.operation),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ipba_dpath #(
        .MAX_PREFIXES (MAX_PREFIXES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire

>>> hdl/ipba_ctrl.sv
// sequencer for the clearing pass, allocate, release and reserve
`default_nettype none
module ipba_ctrl
    import ipba_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_op,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_HIT   = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_A1    = 4'd5;
    localparam logic [3:0] S_A2    = 4'd6;
    localparam logic [3:0] S_A3    = 4'd7;
    localparam logic [3:0] S_A4    = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_ov, n_ov;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    case (i_op)
                        OP_ALLOC: begin
                            if (i_sts.count_zero) begin
                                o_cmd.stage_fail = 1'b1;
                                o_cmd.fail_code  = ST_EXHAUSTED;
                                n_state = S_DONE;
                            end else begin
                                o_cmd.scan_start = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        OP_RELEASE, OP_RESERVE: begin
                            n_state = S_A1;
                        end
                        default: begin
                            o_cmd.stage_fail = 1'b1;
                            o_cmd.fail_code  = ST_BAD_ADDR;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = S_HIT;
                end else if (i_sts.scan_miss) begin
                    o_cmd.stage_fail = 1'b1;
                    o_cmd.fail_code  = ST_EXHAUSTED;
                    n_state = S_DONE;
                end
            end
            S_HIT: begin
                o_cmd.commit_alloc = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.stage_alloc = 1'b1;
                n_state = S_DONE;
            end
            S_A1: begin
                o_cmd.addr_sub = 1'b1;
                n_state = S_A2;
            end
            S_A2: begin
                o_cmd.addr_align = 1'b1;
                n_state = S_A3;
            end
            S_A3: begin
                o_cmd.addr_read = 1'b1;
                if (i_sts.addr_ok) begin
                    n_state = S_A4;
                end else begin
                    o_cmd.stage_fail = 1'b1;
                    o_cmd.fail_code  = ST_BAD_ADDR;
                    n_state = S_DONE;
                end
            end
            S_A4: begin
                o_cmd.addr_update = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (o_cmd.load_out) begin
            n_ov = 1'b1;
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;

endmodule
`default_nettype wire

>>> hdl/ipba_dpath.sv
// bitmap memory, config registers, next-fit scan, address math and result registers
`default_nettype none
module ipba_dpath
    import ipba_pkg::*;
#(
    parameter int MAX_PREFIXES = DEF_MAX_PREFIXES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [HALF_W-1:0]    i_cfg_data,
    input  wire t_in                  i_in,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    output t_out                      o_out
);

    localparam int IDX_W  = $clog2(MAX_PREFIXES);
    localparam int IX_W   = (IDX_W < CNT_W) ? IDX_W : CNT_W;
    localparam int WA_W   = (IDX_W > 6) ? IDX_W - 6 : 1;
    localparam int DEPTH  = 2 ** WA_W;
    localparam int LV_W   = WA_W + 2;
    localparam logic [24:0] MAX_V = 25'(MAX_PREFIXES);
    localparam int AW = 2 * HALF_W;

    // configuration
    logic [HALF_W-1:0] r_start_hi, r_start_lo, r_gw;
    logic [LEN_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_hi <= '0;
            r_start_lo <= '0;
            r_len      <= RESET_LEN;
            r_count    <= RESET_COUNT;
            r_gw       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_HIGH: r_start_hi <= i_cfg_data;
                REG_START_LOW:  r_start_lo <= i_cfg_data;
                REG_PREFIX_LEN: r_len      <= i_cfg_data[LEN_W-1:0];
                REG_COUNT:      r_count    <= i_cfg_data[CNT_W-1:0];
                REG_GATEWAY_ID: r_gw       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [LEN_W-1:0] w_len, w_sh;
    logic [CNT_W-1:0] w_cnt, w_cnt_m1;
    logic [WA_W-1:0]  w_lw;
    logic [AW-1:0]    w_start;

    assign w_len    = (r_len > FULL_LEN) ? FULL_LEN : r_len;
    assign w_sh     = FULL_LEN - w_len;
    assign w_cnt    = ({12'd0, r_count} > MAX_V) ? MAX_V[CNT_W-1:0] : r_count;
    assign w_cnt_m1 = w_cnt - 1'b1;
    assign w_lw     = WA_W'(w_cnt_m1 >> 6);
    assign w_start  = {r_start_hi, r_start_lo};

    // bitmap memory, one word per 64 prefixes
    logic [63:0]     r_mem [DEPTH];
    logic [63:0]     r_rdata;
    logic            w_we;
    logic [WA_W-1:0] w_waddr, w_raddr;
    logic [63:0]     w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // clearing pass
    logic [WA_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // persistent state
    logic [IX_W-1:0]  r_cursor;
    logic [CNT_W-1:0] r_total;
    logic [IX_W-1:0]  w_cur;

    assign w_cur = (CNT_W'(r_cursor) < w_cnt) ? r_cursor : '0;

    // next-fit scan: issue stage and check stage
    logic [WA_W-1:0] r_iw, r_tw;
    logic [LV_W-1:0] r_left;
    logic            r_ifirst, r_tv, r_tfirst, r_tlast;
    logic [5:0]      r_cur_lo;
    logic [63:0]     w_m_cnt, w_m_first, w_m_last, w_free;
    logic [5:0]      w_pe;
    logic            w_hit;

    always_comb begin
        w_pe = '0;
        for (int i = 63; i >= 0; i--) begin
            if (w_free[i]) begin
                w_pe = 6'(i);
            end
        end
    end

    assign w_m_cnt   = (r_tw == w_lw) ? (~64'd0 >> (6'd63 - w_cnt_m1[5:0])) : ~64'd0;
    assign w_m_first = r_tfirst ? (~64'd0 << r_cur_lo) : ~64'd0;
    assign w_m_last  = r_tlast ? ~(~64'd0 << r_cur_lo) : ~64'd0;
    assign w_free    = ~r_rdata & w_m_cnt & w_m_first & w_m_last;
    assign w_hit     = r_tv && (w_free != 64'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv   <= 1'b0;
            r_left <= '0;
        end else if (i_cmd.scan_start) begin
            r_iw     <= WA_W'(w_cur >> 6);
            r_cur_lo <= w_cur[5:0];
            r_left   <= LV_W'(w_lw) + LV_W'(2);
            r_ifirst <= 1'b1;
            r_tv     <= 1'b0;
        end else if (i_cmd.scan_run) begin
            if (r_left != '0) begin
                r_tv     <= 1'b1;
                r_tw     <= r_iw;
                r_tfirst <= r_ifirst;
                r_tlast  <= (r_left == LV_W'(1));
                r_iw     <= (r_iw == w_lw) ? '0 : r_iw + 1'b1;
                r_left   <= r_left - 1'b1;
                r_ifirst <= 1'b0;
            end else begin
                r_tv <= 1'b0;
            end
        end
    end

    // address to index
    t_in             r_in;
    logic [AW-1:0]   r_d;
    logic            r_below, r_qbad;
    logic [IX_W-1:0] r_q, r_bit;
    logic [63:0]     r_word;
    logic [AW-1:0]   w_addr, w_q, w_mask, r_shift;
    logic            w_addr_ok, w_bit_set;

    assign w_addr    = {r_in.addr_high, r_in.addr_low};
    assign w_mask    = ~(~{AW{1'b0}} << w_sh);
    assign w_q       = r_d >> w_sh;
    assign w_addr_ok = !r_qbad && (CNT_W'(r_q) < w_cnt);
    assign w_bit_set = r_rdata[r_bit[5:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_in <= i_in;
        end
        if (i_cmd.addr_sub) begin
            r_d     <= w_addr - w_start;
            r_below <= (w_addr < w_start);
        end
        if (i_cmd.addr_align) begin
            r_q    <= IX_W'(w_q);
            r_qbad <= r_below || ((r_d & w_mask) != '0) || ((w_q >> IX_W) != '0);
        end
        if (i_cmd.scan_run && w_hit) begin
            r_bit  <= IX_W'({r_tw, w_pe});
            r_word <= r_rdata | (64'd1 << w_pe);
        end else if (i_cmd.addr_read) begin
            r_bit <= r_q;
        end
        if (i_cmd.commit_alloc) begin
            r_shift <= {{(AW-IX_W){1'b0}}, r_bit} << w_sh;
        end
    end

    assign w_raddr = i_cmd.addr_read ? WA_W'(r_q >> 6) : r_iw;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = WA_W'(r_bit >> 6);
        w_wdata = r_word;
        if (i_cmd.clr) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else if (i_cmd.commit_alloc) begin
            w_we = 1'b1;
        end else if (i_cmd.addr_update) begin
            w_we = (r_in.operation == OP_RELEASE) ? w_bit_set : !w_bit_set;
            w_wdata = r_rdata ^ (64'd1 << r_bit[5:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_total  <= '0;
        end else if (i_cmd.commit_alloc) begin
            r_total  <= r_total + 1'b1;
            r_cursor <= ((CNT_W + 1)'(r_bit) + 1'b1 >= (CNT_W + 1)'(w_cnt))
                        ? '0 : r_bit + 1'b1;
        end else if (i_cmd.addr_update) begin
            if (r_in.operation == OP_RELEASE) begin
                if (w_bit_set && r_total != '0) begin
                    r_total <= r_total - 1'b1;
                end
            end else if (!w_bit_set) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    // result staging and output register
    logic [1:0]        r_st_status;
    logic [IX_W-1:0]   r_st_idx;
    logic [HALF_W-1:0] r_st_rh, r_st_rl, r_st_lid, r_st_pid;
    logic [AW-1:0]     w_sum;

    assign w_sum = w_start + r_shift;

    always_ff @(posedge i_clk) begin
        if (i_cmd.stage_fail) begin
            r_st_status <= i_cmd.fail_code;
            r_st_idx    <= '0;
            r_st_rh     <= '0;
            r_st_rl     <= '0;
            r_st_lid    <= '0;
            r_st_pid    <= '0;
        end else if (i_cmd.stage_alloc) begin
            r_st_status <= ST_DONE;
            r_st_idx    <= r_bit;
            r_st_rh     <= w_sum[AW-1:HALF_W];
            r_st_rl     <= w_sum[HALF_W-1:0];
            r_st_lid    <= (w_len == FULL_LEN) ? r_gw : '0;
            r_st_pid    <= (w_len == FULL_LEN) ? w_sum[HALF_W-1:0] : '0;
        end else if (i_cmd.addr_update) begin
            r_st_status <= (w_bit_set == (r_in.operation == OP_RELEASE))
                           ? ST_DONE : ST_NO_CHANGE;
            r_st_idx    <= r_bit;
            r_st_rh     <= '0;
            r_st_rl     <= '0;
            r_st_lid    <= '0;
            r_st_pid    <= '0;
        end
        if (i_cmd.load_out) begin
            o_out.status             <= r_st_status;
            o_out.bit_index          <= IDX_OUT_W'(r_st_idx);
            o_out.result_high        <= r_st_rh;
            o_out.result_low         <= r_st_rl;
            o_out.result_prefix_len  <= w_len;
            o_out.local_interface_id <= r_st_lid;
            o_out.peer_interface_id  <= r_st_pid;
            o_out.used_count         <= r_total;
        end
    end

    assign o_sts.clr_last   = (r_clr_addr == WA_W'(DEPTH - 1));
    assign o_sts.count_zero = (w_cnt == '0);
    assign o_sts.scan_hit   = w_hit;
    assign o_sts.scan_miss  = r_tv && r_tlast && !w_hit;
    assign o_sts.addr_ok    = w_addr_ok;

endmodule
`default_nettype wire

>>> hdl/ipba_checker.sv
// port-level checks for the allocator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module ipba_checker
    import ipba_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_out o_out
);

    `IPBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))
    `IPBA_ASSERT_NOW(a_len_range, i_clk, i_rst_n, o_out_valid, o_out.result_prefix_len <= FULL_LEN)
    `IPBA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_out_valid && (o_out.status == ST_EXHAUSTED || o_out.status == ST_BAD_ADDR), o_out.bit_index == '0 && o_out.result_low == '0)
    `IPBA_ASSERT_NOW(a_ifid_only_128, i_clk, i_rst_n, o_out_valid && o_out.result_prefix_len != FULL_LEN, o_out.local_interface_id == '0 && o_out.peer_interface_id == '0)

endmodule

bind ipv6_prefix_bitmap_allocator_unit ipba_checker u_ipba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire

>>> dv/tb.sv
// self-checking testbench of the ipv6 prefix bitmap allocator
`default_nettype none
module tb;
    import ipba_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NUM_PREFIXES = DEF_MAX_PREFIXES;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic [1:0]   op;
        logic [127:0] addr;
        bit           typed;
        logic [1:0]   st;
        int           idx;
        int           used;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [HALF_W-1:0] cfg_data = '0;
    t_in in_beat = '0;
    logic in_ready;
    logic out_valid;
    t_out out_beat;

    // allocator state mirrored by the testbench
    logic [127:0] range_start;
    logic [7:0] lease_len;
    logic [12:0] lease_count;
    logic [63:0] gateway_id;
    bit lease_map [NUM_PREFIXES];
    int next_cursor;
    int leases_held;

    t_out pending_leases[$];
    int errors = 0;
    bit idling = 1'b1;
    bit long_hold = 1'b0;

    always #1 i_clk = ~i_clk;

    ipv6_prefix_bitmap_allocator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_beat),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_beat),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    function automatic int eff_count();
        return lease_count > NUM_PREFIXES ? NUM_PREFIXES : int'(lease_count);
    endfunction

    function automatic int eff_shift();
        return 128 - (lease_len > 8'd128 ? 128 : int'(lease_len));
    endfunction

    function automatic t_out predict_lease(t_in it);
        t_out r;
        int cnt;
        int sh;
        int cur;
        int b;
        bit found;
        logic [127:0] sum;
        logic [127:0] addr;
        logic [127:0] diff;
        logic [127:0] mask;
        logic [127:0] q;
        cnt = eff_count();
        sh = eff_shift();
        r = '0;
        r.result_prefix_len = 8'(128 - sh);
        found = 1'b0;
        b = 0;
        case (it.operation)
            OP_ALLOC: begin
                cur = next_cursor < cnt ? next_cursor : 0;
                for (int k = 0; k < cnt && !found; k++) begin
                    b = cur + k;
                    if (b >= cnt) b -= cnt;
                    if (!lease_map[b]) found = 1'b1;
                end
                if (!found) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    lease_map[b] = 1'b1;
                    leases_held++;
                    next_cursor = (b + 1 >= cnt) ? 0 : b + 1;
                    sum = range_start + (128'(b) << sh);
                    r.status = ST_DONE;
                    r.bit_index = 12'(b);
                    r.result_high = sum[127:64];
                    r.result_low = sum[63:0];
                    if (sh == 0) begin
                        r.local_interface_id = gateway_id;
                        r.peer_interface_id = sum[63:0];
                    end
                end
            end
            OP_RELEASE, OP_RESERVE: begin
                addr = {it.addr_high, it.addr_low};
                diff = addr - range_start;
                mask = sh >= 128 ? '1 : (128'(1) << sh) - 128'(1);
                q = diff >> sh;
                if (addr < range_start || (diff & mask) != 0 || q >= 128'(cnt)) begin
                    r.status = ST_BAD_ADDR;
                end else begin
                    b = int'(q);
                    r.bit_index = 12'(b);
                    if (it.operation == OP_RELEASE) begin
                        if (!lease_map[b]) r.status = ST_NO_CHANGE;
                        else begin
                            lease_map[b] = 1'b0;
                            if (leases_held > 0) leases_held--;
                        end
                    end else begin
                        if (lease_map[b]) r.status = ST_NO_CHANGE;
                        else begin
                            lease_map[b] = 1'b1;
                            leases_held++;
                        end
                    end
                end
            end
            default: r.status = ST_BAD_ADDR;
        endcase
        r.used_count = 13'(leases_held);
        return r;
    endfunction

    // random item: mostly allocs and hits on real prefixes, some noise
    function automatic t_in make_item();
        t_in it;
        int pick;
        int cnt;
        logic [127:0] a;
        pick = $urandom_range(99);
        cnt = eff_count();
        a = range_start + (128'($urandom_range(cnt > 0 ? cnt - 1 : 0)) << eff_shift());
        it.operation = OP_ALLOC;
        it.addr_high = {$urandom, $urandom};
        it.addr_low = {$urandom, $urandom};
        if (pick < 40) begin
            it.operation = OP_ALLOC;
        end else if (pick < 85) begin
            it.operation = pick < 70 ? OP_RELEASE : OP_RESERVE;
            if (pick % 9 == 0) a = a + 128'(1) + 128'($urandom_range(3));
            {it.addr_high, it.addr_low} = a;
        end else if (pick < 95) begin
            it.operation = pick[0] ? OP_RELEASE : OP_RESERVE;
        end else begin
            it.operation = OP_UNUSED;
        end
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            REG_START_HIGH: range_start[127:64] = val;
            REG_START_LOW:  range_start[63:0] = val;
            REG_PREFIX_LEN: lease_len = val[7:0];
            REG_COUNT:      lease_count = val[12:0];
            REG_GATEWAY_ID: gateway_id = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_range(input logic [127:0] start, input logic [7:0] len,
                             input logic [12:0] cnt, input logic [63:0] gw);
        wait (pending_leases.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_START_HIGH, start[127:64]);
        write_reg(REG_START_LOW, start[63:0]);
        write_reg(REG_PREFIX_LEN, 64'(len));
        write_reg(REG_COUNT, 64'(cnt));
        write_reg(REG_GATEWAY_ID, gw);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // valid stays high from one beat to the next unless an idle burst follows
    task automatic send_beat(input t_in it, output t_out predicted);
        if (idling && $urandom_range(5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        predicted = predict_lease(it);
        pending_leases.push_back(predicted);
    endtask

    task automatic run_random(input int n);
        t_out p;
        repeat (n) send_beat(make_item(), p);
    endtask

    // result side stalls
    initial begin
        out_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (idling && $urandom_range(7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(16, 1)) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out exp_lease;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_leases.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                exp_lease = pending_leases.pop_front();
                if (out_beat.status !== exp_lease.status) begin
                    $error("status exp %0d got %0d", exp_lease.status, out_beat.status);
                    errors++;
                end
                if (out_beat.bit_index !== exp_lease.bit_index) begin
                    $error("bit_index exp %0d got %0d", exp_lease.bit_index,
                           out_beat.bit_index);
                    errors++;
                end
                if (out_beat.result_high !== exp_lease.result_high) begin
                    $error("result_high exp %h got %h", exp_lease.result_high,
                           out_beat.result_high);
                    errors++;
                end
                if (out_beat.result_low !== exp_lease.result_low) begin
                    $error("result_low exp %h got %h", exp_lease.result_low,
                           out_beat.result_low);
                    errors++;
                end
                if (out_beat.result_prefix_len !== exp_lease.result_prefix_len) begin
                    $error("result_prefix_len exp %0d got %0d",
                           exp_lease.result_prefix_len, out_beat.result_prefix_len);
                    errors++;
                end
                if (out_beat.local_interface_id !== exp_lease.local_interface_id) begin
                    $error("local_interface_id exp %h got %h",
                           exp_lease.local_interface_id, out_beat.local_interface_id);
                    errors++;
                end
                if (out_beat.peer_interface_id !== exp_lease.peer_interface_id) begin
                    $error("peer_interface_id exp %h got %h",
                           exp_lease.peer_interface_id, out_beat.peer_interface_id);
                    errors++;
                end
                if (out_beat.used_count !== exp_lease.used_count) begin
                    $error("used_count exp %0d got %0d", exp_lease.used_count,
                           out_beat.used_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_dir_row rows [12];
        t_in it;
        t_out p;
        range_start = '0;
        lease_len = RESET_LEN;
        lease_count = RESET_COUNT;
        gateway_id = '0;
        next_cursor = 0;
        leases_held = 0;
        foreach (lease_map[i]) lease_map[i] = 1'b0;
        // default range: start 0, /64 prefixes, 4096 of them
        rows = '{
            '{OP_ALLOC,   128'h0,                1, ST_DONE,      0,    1},
            '{OP_ALLOC,   128'h0,                1, ST_DONE,      1,    2},
            '{OP_RELEASE, {64'd1, 64'd0},        1, ST_DONE,      1,    1},
            '{OP_RELEASE, {64'd1, 64'd0},        1, ST_NO_CHANGE, 1,    1},
            '{OP_RELEASE, {64'd0, 64'd5},        1, ST_BAD_ADDR,  0,    1},
            '{OP_UNUSED,  '1,                    1, ST_BAD_ADDR,  0,    1},
            '{OP_RESERVE, {64'd4095, 64'd0},     1, ST_DONE,      4095, 2},
            '{OP_RESERVE, {64'd4095, 64'd0},     1, ST_NO_CHANGE, 4095, 2},
            '{OP_RESERVE, {64'd4096, 64'd0},     1, ST_BAD_ADDR,  0,    2},
            '{OP_RESERVE, '1,                    1, ST_BAD_ADDR,  0,    2},
            '{OP_RELEASE, 128'h0,                1, ST_DONE,      0,    1},
            '{OP_ALLOC,   128'h0,                0, ST_DONE,      0,    0}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[r]) begin
            it.operation = rows[r].op;
            {it.addr_high, it.addr_low} = rows[r].addr;
            send_beat(it, p);
            if (rows[r].typed) begin
                void'(pending_leases.pop_back());
                p.status = rows[r].st;
                p.bit_index = 12'(rows[r].idx);
                p.used_count = 13'(rows[r].used);
                pending_leases.push_back(p);
            end
        end
        in_valid <= 1'b0;

        // small /128 pool: interface ids, frequent exhaustion, and a long output stall
        set_range({$urandom, $urandom, $urandom, $urandom}, 8'd128, 13'd64,
                  {$urandom, $urandom});
        long_hold = 1'b1;
        run_random(150);
        in_valid <= 1'b0;
        // start near the top of the space with /7 steps: carries get dropped
        set_range({64'hffff_ffff_ffff_ff00, {$urandom, $urandom}}, 8'd7, 13'd4096, '1);
        run_random(120);
        in_valid <= 1'b0;
        // length above 128 and count above the bitmap size
        set_range('1, 8'd255, 13'h1fff, 64'h0);
        run_random(120);
        in_valid <= 1'b0;
        // empty range
        set_range({$urandom, $urandom, 64'h0}, 8'd64, 13'd0, {$urandom, $urandom});
        run_random(40);
        in_valid <= 1'b0;
        // single prefix covering the whole space
        set_range('0, 8'd0, 13'd1, {$urandom, $urandom});
        run_random(80);
        in_valid <= 1'b0;
        set_range({$urandom, $urandom, $urandom, $urandom}, 8'($urandom_range(128, 7)),
                  13'($urandom_range(300, 1)), {$urandom, $urandom});
        run_random(150);
        in_valid <= 1'b0;
        set_range({$urandom, $urandom, 64'h0}, 8'd96, 13'd200, {$urandom, $urandom});
        idling = 1'b0;
        run_random(150);
        in_valid <= 1'b0;

        wait (pending_leases.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS ipv6_prefix_bitmap_allocator_unit");
        end else begin
            $display("FAIL ipv6_prefix_bitmap_allocator_unit");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL ipv6_prefix_bitmap_allocator_unit");
        $finish;
    end

endmodule
`default_nettype wire
